>>> rtl/slrd_pkg.sv
// Shared types and constants for the store-to-load reuse detector.
// Holds the op codes, the scan token that walks the cell chain and the commit bus.
// No dependencies.
`timescale 1ns / 1ps

package slrd_pkg;

  // Default table depth and reset value of the window register.
  localparam int unsigned TableEntries = 64;
  localparam logic [31:0] WindowReset  = 32'd1000000;

  // Event op codes.
  localparam logic [2:0] OP_STORE  = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_RETIRE = 3'd2;
  localparam logic [2:0] OP_BEGIN  = 3'd3;
  localparam logic [2:0] OP_END    = 3'd4;

  // Preference of a cell as the slot for a store, lowest to highest.
  typedef enum logic [1:0] {
    RANK_OLDEST,
    RANK_EXPIRED,
    RANK_FREE,
    RANK_MATCH
  } slrd_rank_t;

  // Scan token handed from cell to cell, one hop per cycle.
  typedef struct packed {
    logic        vld;
    logic        is_load;
    logic [63:0] address;
    logic [63:0] tick;
    logic        hit;
    logic [63:0] hit_pc;
    logic [63:0] hit_tick;
    logic [63:0] hit_icount;
    slrd_rank_t  rank;
    logic        any;
    logic [63:0] best_age;
  } slrd_tok_t;

  // Table update broadcast from the controller to every cell.
  typedef struct packed {
    logic        clear_all;
    logic        write;
    logic        drop;
    logic [63:0] address;
    logic [63:0] pc;
    logic [63:0] tick;
    logic [63:0] icount;
  } slrd_commit_t;

endpackage

>>> rtl/store_load_reuse_detector_top.sv
// Store-to-load reuse detector: controller, result register and the chain of entry cells.
// Depends on slrd_pkg and slrd_cell.
// A tracked store or load walks the chain one cell per cycle; the input stalls until it
// leaves the finish state, where a spill record may wait behind a stalled earlier one.
// A load's spill record enters the result register as it leaves; other items do not stall the input.
// Synchronous reset empties the table, leaves the region inactive and zeroes the counters.
`timescale 1ns / 1ps

module store_load_reuse_detector_top #(
  parameter int unsigned TABLE_ENTRIES = slrd_pkg::TableEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [63:0] address,
  input  logic [63:0] pc,
  input  logic [63:0] tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] st_pc,
  output logic [63:0] load_pc,
  output logic [63:0] spill_address,
  output logic [63:0] st_tick,
  output logic [63:0] ld_tick,
  output logic [63:0] tick_gap,
  output logic [63:0] store_instr_count,
  output logic [63:0] load_instr_count,
  output logic [63:0] spill_count
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                 state;
  logic [31:0]            spill_window;
  logic                   region_active;
  logic [63:0]            instr_counter;
  logic [63:0]            spill_counter;
  logic [63:0]            item_pc;
  slrd_pkg::slrd_tok_t    fin;
  logic [IDX_W-1:0]       fin_slot;

  slrd_pkg::slrd_tok_t    tok  [TABLE_ENTRIES+1];
  logic [IDX_W-1:0]       slot [TABLE_ENTRIES+1];
  slrd_pkg::slrd_commit_t cmt;

  logic accept;
  logic tracked;
  logic spill;
  logic out_free;
  logic emit;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign tracked   = region_active && ((op == slrd_pkg::OP_STORE) || (op == slrd_pkg::OP_LOAD));
  assign spill     = fin.hit && (fin.tick > fin.hit_tick);
  assign out_free  = !out_valid || !out_stall;
  assign emit      = (state == S_FINISH) && fin.is_load && spill && out_free;

  // Token injected into the first cell when a tracked access is accepted.
  always_comb begin
    tok[0]            = '0;
    tok[0].vld        = accept && tracked;
    tok[0].is_load    = (op == slrd_pkg::OP_LOAD);
    tok[0].address    = address;
    tok[0].tick       = tick;
    tok[0].rank       = slrd_pkg::RANK_OLDEST;
    slot[0]           = '0;
  end

  // Table updates: region end clears, a finished store writes its chosen slot.
  always_comb begin
    cmt.clear_all = accept && (op == slrd_pkg::OP_END);
    cmt.write     = (state == S_FINISH) && !fin.is_load;
    cmt.drop      = (fin.rank == slrd_pkg::RANK_EXPIRED);
    cmt.address   = fin.address;
    cmt.pc        = item_pc;
    cmt.tick      = fin.tick;
    cmt.icount    = instr_counter;
  end

  // Chain of entry cells.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    slrd_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .window   (spill_window),
      .tok_i    (tok[g]),
      .slot_i   (slot[g]),
      .tok_o    (tok[g+1]),
      .slot_o   (slot[g+1]),
      .cmt      (cmt),
      .cmt_slot (fin_slot)
    );
  end

  // Window register.
  always_ff @(posedge clk) begin
    if (rst) begin
      spill_window <= slrd_pkg::WindowReset;
    end else if (cfg_valid && cfg_ready) begin
      spill_window <= cfg_data;
    end
  end

  // Payload of the item in flight and of the token leaving the chain.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_pc <= pc;
    end
    if ((state == S_SCAN) && tok[TABLE_ENTRIES].vld) begin
      fin      <= tok[TABLE_ENTRIES];
      fin_slot <= slot[TABLE_ENTRIES];
    end
  end

  // Controller, counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      region_active <= 1'b0;
      instr_counter <= '0;
      spill_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      // A new spill record takes the register as the previous one leaves.
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (op) inside
              slrd_pkg::OP_STORE, slrd_pkg::OP_LOAD: begin
                if (region_active) begin
                  state <= S_SCAN;
                end
              end
              slrd_pkg::OP_RETIRE: instr_counter <= instr_counter + 64'd1;
              slrd_pkg::OP_BEGIN:  region_active <= 1'b1;
              slrd_pkg::OP_END:    region_active <= 1'b0;
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (tok[TABLE_ENTRIES].vld) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!fin.is_load || !spill) begin
            state <= S_IDLE;
          end else if (emit) begin
            st_pc             <= fin.hit_pc;
            load_pc           <= item_pc;
            spill_address     <= fin.address;
            st_tick           <= fin.hit_tick;
            ld_tick           <= fin.tick;
            tick_gap          <= fin.tick - fin.hit_tick;
            store_instr_count <= fin.hit_icount;
            load_instr_count  <= instr_counter;
            spill_count       <= spill_counter + 64'd1;
            spill_counter     <= spill_counter + 64'd1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/slrd_cell.sv
// One table entry of the store-to-load reuse detector, with its token stage.
// Depends on slrd_pkg for the token and commit types.
`timescale 1ns / 1ps

module slrd_cell #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [31:0]              window,
  input  slrd_pkg::slrd_tok_t      tok_i,
  input  logic [IDX_W-1:0]         slot_i,
  output slrd_pkg::slrd_tok_t      tok_o,
  output logic [IDX_W-1:0]         slot_o,
  input  slrd_pkg::slrd_commit_t   cmt,
  input  logic [IDX_W-1:0]         cmt_slot
);

  logic                valid;
  logic                exp_flag;
  logic [63:0]         e_addr;
  logic [63:0]         e_pc;
  logic [63:0]         e_tick;
  logic [63:0]         e_icount;
  slrd_pkg::slrd_tok_t tok_q;
  logic [IDX_W-1:0]    slot_q;

  logic [63:0]          age;
  logic                 expired;
  logic                 match;
  logic                 take;
  logic                 own_slot;
  slrd_pkg::slrd_rank_t cand;
  slrd_pkg::slrd_tok_t  tok_next;
  logic [IDX_W-1:0]     slot_next;

  assign own_slot = (cmt_slot == IDX_W'(CELL_IDX));

  // Evaluate this entry against the passing token and update the token.
  always_comb begin
    age     = tok_i.tick - e_tick;
    expired = valid && (age > {32'd0, window});
    match   = valid && (e_addr == tok_i.address);
    if (match) begin
      cand = slrd_pkg::RANK_MATCH;
    end else if (!valid) begin
      cand = slrd_pkg::RANK_FREE;
    end else if (expired) begin
      cand = slrd_pkg::RANK_EXPIRED;
    end else begin
      cand = slrd_pkg::RANK_OLDEST;
    end
    // Earlier cells win ties, except among live entries where the older one wins.
    take = !tok_i.any || (cand > tok_i.rank) ||
           ((cand == tok_i.rank) && (cand == slrd_pkg::RANK_OLDEST) &&
            (age > tok_i.best_age));
    tok_next  = tok_i;
    slot_next = slot_i;
    if (tok_i.is_load) begin
      if (match && !expired) begin
        tok_next.hit        = 1'b1;
        tok_next.hit_pc     = e_pc;
        tok_next.hit_tick   = e_tick;
        tok_next.hit_icount = e_icount;
      end
    end else if (take) begin
      tok_next.rank     = cand;
      tok_next.any      = 1'b1;
      tok_next.best_age = age;
      slot_next         = IDX_W'(CELL_IDX);
    end
  end

  // Token stage toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.vld <= 1'b0;
    end else begin
      tok_q <= tok_next;
    end
    slot_q <= slot_next;
  end

  // Valid bit and expiry mark of this entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      exp_flag <= 1'b0;
    end else if (cmt.clear_all) begin
      valid <= 1'b0;
    end else if (tok_i.vld) begin
      if (tok_i.is_load) begin
        if (expired || match) begin
          valid <= 1'b0;
        end
      end else begin
        exp_flag <= expired;
      end
    end else if (cmt.write) begin
      if (own_slot) begin
        valid <= 1'b1;
      end else if (cmt.drop && exp_flag) begin
        valid <= 1'b0;
      end
    end
  end

  // Entry payload, written by a store commit aimed at this cell.
  always_ff @(posedge clk) begin
    if (cmt.write && own_slot) begin
      e_addr   <= cmt.address;
      e_pc     <= cmt.pc;
      e_tick   <= cmt.tick;
      e_icount <= cmt.icount;
    end
  end

  assign tok_o  = tok_q;
  assign slot_o = slot_q;

endmodule
